>>> sv/sr6_pkg.sv
// package: types, constants and helpers for the symmetric rank update accumulator
`default_nettype none
package sr6_pkg;
    localparam int DIM_DEF       = 6;
    localparam int ELEM_BITS_DEF = 16;
    localparam int ACC_BITS_DEF  = 48;
    localparam int NUM_COLS      = 6;
    localparam int OUT_BITS      = 48;
    localparam int NUM_ENTRIES   = (DIM_DEF * (DIM_DEF + 1)) / 2;
    localparam int IDX_BITS      = $clog2(NUM_ENTRIES);

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_RANK1 = 3'd1;
    localparam logic [2:0] OP_RANK2 = 3'd2;
    localparam logic [2:0] OP_ADD   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic signed [47:0] entry_value;
        logic [2:0]         entry_col;
        logic [2:0]         entry_row;
        logic [63:0]        weight;
        logic [31:0]        col_5;
        logic [31:0]        col_4;
        logic [31:0]        col_3;
        logic [31:0]        col_2;
        logic [31:0]        col_1;
        logic [31:0]        col_0;
        logic [2:0]         opcode;
    } in_item_t;

    typedef struct packed {
        logic               saturated;
        logic signed [47:0] read_value;
    } out_item_t;

    // upper-triangle linear index of (r,c), r <= c
    function automatic logic [IDX_BITS-1:0] tri_index(input logic [2:0] r, input logic [2:0] c);
        int ri, ci;
        ri = int'(r);
        ci = int'(c);
        return IDX_BITS'(ri * DIM_DEF - (ri * (ri - 1)) / 2 + (ci - ri));
    endfunction
endpackage
`default_nettype wire

>>> sv/sr6_lane.sv
// lane: forms u = W^T v for one column, truncated and saturated
`default_nettype none
module sr6_lane #(
    parameter int ELEM_BITS = sr6_pkg::ELEM_BITS_DEF
) (
    input  wire logic signed [ELEM_BITS-1:0] va,
    input  wire logic signed [ELEM_BITS-1:0] vb,
    input  wire logic signed [ELEM_BITS-1:0] w11,
    input  wire logic signed [ELEM_BITS-1:0] w21,
    input  wire logic signed [ELEM_BITS-1:0] w12,
    input  wire logic signed [ELEM_BITS-1:0] w22,
    output logic signed [ELEM_BITS-1:0] ua,
    output logic signed [ELEM_BITS-1:0] ub,
    output logic                        sat
);
    localparam int FRAC = ELEM_BITS - 4;
    localparam int PW   = 2 * ELEM_BITS + 1;
    localparam int SW   = PW - FRAC;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (ELEM_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic signed [PW-1:0] sa, sb;
    logic signed [SW-1:0] fa, fb;
    logic                 oa, ob;

    always_comb begin
        sa = PW'(w11 * va) + PW'(w21 * vb);
        sb = PW'(w12 * va) + PW'(w22 * vb);
        fa = SW'(sa >>> FRAC);
        fb = SW'(sb >>> FRAC);
        oa = (fa > HI) || (fa < LO);
        ob = (fb > HI) || (fb < LO);
        ua = (fa > HI) ? HI[ELEM_BITS-1:0] : (fa < LO) ? LO[ELEM_BITS-1:0] : fa[ELEM_BITS-1:0];
        ub = (fb > HI) ? HI[ELEM_BITS-1:0] : (fb < LO) ? LO[ELEM_BITS-1:0] : fb[ELEM_BITS-1:0];
        sat = oa || ob;
    end
endmodule
`default_nettype wire

>>> sv/sr6_merge.sv
// merge: saturating add of one term (a dot term or an added value) into one stored entry
`default_nettype none
module sr6_merge #(
    parameter int ACC_BITS = sr6_pkg::ACC_BITS_DEF,
    parameter int TERM_BITS = 34
) (
    input  wire logic signed [ACC_BITS-1:0]  acc,
    input  wire logic signed [TERM_BITS-1:0] term,
    output logic signed [ACC_BITS-1:0]       sum,
    output logic                             sat
);
    localparam int SW = (ACC_BITS > TERM_BITS ? ACC_BITS : TERM_BITS) + 1;
    localparam logic signed [SW-1:0] HI = SW'((65'sd1 <<< (ACC_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);
    logic signed [SW-1:0] s;

    always_comb begin
        s   = SW'(acc) + SW'(term);
        sat = (s > HI) || (s < LO);
        sum = (s > HI) ? HI[ACC_BITS-1:0] : (s < LO) ? LO[ACC_BITS-1:0] : s[ACC_BITS-1:0];
    end
endmodule
`default_nettype wire

>>> sv/symmetric_6x6_rank_update_accumulator_core.sv
// top level: symmetric 6x6 rank update accumulator core
// Takes one item per transfer and answers each with one result. An item is handled in order:
// first the per-column u terms from six lane units are registered; then a rank update forms
// every dot term and merges it into the 21 stored entries (an add merges into one entry, a
// clear zeroes them, a read fetches one) and the result is registered. No new item is taken
// while one is in flight; a waiting result holds off the next item until the result is taken.
`default_nettype none
module symmetric_6x6_rank_update_accumulator_core #(
    parameter int DIM       = sr6_pkg::DIM_DEF,
    parameter int ELEM_BITS = sr6_pkg::ELEM_BITS_DEF,
    parameter int ACC_BITS  = sr6_pkg::ACC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sr6_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sr6_pkg::out_item_t     m_data
);
    localparam int NE   = (DIM * (DIM + 1)) / 2;
    localparam int IB   = (NE > 1) ? $clog2(NE) : 1;
    localparam int TB   = 2 * ELEM_BITS + 1;
    localparam int COLB = 32;

    logic                  busy_reg, busy_next;
    sr6_pkg::in_item_t     item_reg;
    logic signed [ELEM_BITS-1:0] ua_reg [DIM];
    logic signed [ELEM_BITS-1:0] ub_reg [DIM];
    logic signed [ELEM_BITS-1:0] va_reg [DIM];
    logic signed [ELEM_BITS-1:0] vb_reg [DIM];
    logic                  usat_reg;
    logic signed [ACC_BITS-1:0] ent_reg [NE];
    logic                  out_valid_reg;
    sr6_pkg::out_item_t    out_reg, out_next;

    logic [COLB-1:0]             cols [DIM];
    logic signed [ELEM_BITS-1:0] va [DIM];
    logic signed [ELEM_BITS-1:0] vb [DIM];
    logic signed [ELEM_BITS-1:0] ua [DIM];
    logic signed [ELEM_BITS-1:0] ub [DIM];
    logic [DIM-1:0]              lsat;
    logic signed [ELEM_BITS-1:0] w11, w21, w12, w22;
    logic                        two;

    logic signed [TB-1:0]        term [DIM][DIM];
    logic signed [ACC_BITS-1:0]  msum [DIM][DIM];
    logic [DIM-1:0]              msat [DIM];
    logic                        rank_sat;

    logic signed [ACC_BITS-1:0] asum;
    logic                       asat;
    logic                       inr;
    logic [IB-1:0]              eidx;
    logic [2:0]                 lo_rc, hi_rc;
    logic                       accept, finish;

    assign accept  = s_valid && s_ready;
    assign s_ready = !busy_reg && (!out_valid_reg || m_ready);
    assign finish  = busy_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        cols[0] = s_data.col_0;
        if (DIM > 1) cols[1 % DIM] = s_data.col_1;
        for (int k = 2; k < DIM; k++) cols[k] = '0;
        if (DIM > 2) cols[2 % DIM] = s_data.col_2;
        if (DIM > 3) cols[3 % DIM] = s_data.col_3;
        if (DIM > 4) cols[4 % DIM] = s_data.col_4;
        if (DIM > 5) cols[5 % DIM] = s_data.col_5;
        two = (s_data.opcode == sr6_pkg::OP_RANK2);
        w11 = s_data.weight[ELEM_BITS-1:0];
        w21 = two && (2 * ELEM_BITS <= 64) ? s_data.weight[(2*ELEM_BITS-1)%64 -: ELEM_BITS] : '0;
        w12 = two && (3 * ELEM_BITS <= 64) ? s_data.weight[(3*ELEM_BITS-1)%64 -: ELEM_BITS] : '0;
        w22 = two && (4 * ELEM_BITS <= 64) ? s_data.weight[(4*ELEM_BITS-1)%64 -: ELEM_BITS] : '0;
        for (int k = 0; k < DIM; k++) begin
            va[k] = cols[k][ELEM_BITS-1:0];
            vb[k] = two && (2 * ELEM_BITS <= COLB) ?
                    cols[k][(2*ELEM_BITS-1)%COLB -: ELEM_BITS] : '0;
        end
    end

    for (genvar k = 0; k < DIM; k++) begin : g_lane
        sr6_lane #(.ELEM_BITS(ELEM_BITS)) u_lane (
            .va(va[k]), .vb(vb[k]), .w11(w11), .w21(w21), .w12(w12), .w22(w22),
            .ua(ua[k]), .ub(ub[k]), .sat(lsat[k])
        );
    end

    for (genvar i = 0; i < DIM; i++) begin : g_row
        for (genvar j = 0; j < DIM; j++) begin : g_col
            if (j >= i) begin : g_up
                localparam int IX = i * DIM - (i * (i - 1)) / 2 + (j - i);
                assign term[i][j] = TB'(ua_reg[i] * va_reg[j]) + TB'(ub_reg[i] * vb_reg[j]);
                sr6_merge #(.ACC_BITS(ACC_BITS), .TERM_BITS(TB)) u_merge (
                    .acc(ent_reg[IX]), .term(term[i][j]), .sum(msum[i][j]), .sat(msat[i][j])
                );
            end else begin : g_lo
                assign term[i][j] = '0;
                assign msum[i][j] = '0;
                assign msat[i][j] = 1'b0;
            end
        end
    end

    always_comb begin
        lo_rc = (item_reg.entry_row > item_reg.entry_col) ? item_reg.entry_col
                                                          : item_reg.entry_row;
        hi_rc = (item_reg.entry_row > item_reg.entry_col) ? item_reg.entry_row
                                                          : item_reg.entry_col;
        inr   = (32'(item_reg.entry_row) < DIM) && (32'(item_reg.entry_col) < DIM);
        eidx  = IB'(int'(lo_rc) * DIM - (int'(lo_rc) * (int'(lo_rc) - 1)) / 2
                + (int'(hi_rc) - int'(lo_rc)));
    end

    sr6_merge #(.ACC_BITS(ACC_BITS), .TERM_BITS(48)) u_addmerge (
        .acc(ent_reg[eidx]), .term(item_reg.entry_value), .sum(asum), .sat(asat)
    );

    always_comb begin
        rank_sat = usat_reg;
        for (int i = 0; i < DIM; i++) rank_sat = rank_sat | (|msat[i]);
    end

    always_comb begin
        out_next = '0;
        unique case (item_reg.opcode)
            sr6_pkg::OP_RANK1, sr6_pkg::OP_RANK2: begin
                out_next.saturated = rank_sat;
            end
            sr6_pkg::OP_ADD: begin
                if (inr) out_next.saturated = asat;
            end
            sr6_pkg::OP_READ: begin
                if (inr) out_next.read_value = 48'(ent_reg[eidx]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) busy_next = 1'b1;
        else if (finish) busy_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < NE; e++) ent_reg[e] <= '0;
        end else begin
            busy_reg <= busy_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
                unique case (item_reg.opcode)
                    sr6_pkg::OP_CLEAR: begin
                        for (int e = 0; e < NE; e++) ent_reg[e] <= '0;
                    end
                    sr6_pkg::OP_RANK1, sr6_pkg::OP_RANK2: begin
                        for (int i = 0; i < DIM; i++) begin
                            for (int j = i; j < DIM; j++) begin
                                ent_reg[i * DIM - (i * (i - 1)) / 2 + (j - i)] <= msum[i][j];
                            end
                        end
                    end
                    sr6_pkg::OP_ADD: begin
                        if (inr) ent_reg[eidx] <= asum;
                    end
                    default: begin
                    end
                endcase
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            usat_reg <= |lsat;
            for (int k = 0; k < DIM; k++) begin
                ua_reg[k] <= ua[k];
                ub_reg[k] <= ub[k];
                va_reg[k] <= va[k];
                vb_reg[k] <= vb[k];
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/sr6_checker.sv
// checker: port-level properties of the accumulator core, bound to the top level
`default_nettype none
module sr6_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire sr6_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire sr6_pkg::out_item_t m_data
);
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("input taken while busy");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 m_valid) else $error("result missing");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))) else $error("result dropped");
    a_read_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.opcode == sr6_pkg::OP_READ)) |=> ##1 !m_data.saturated)
        else $error("read flagged saturation");
endmodule

bind symmetric_6x6_rank_update_accumulator_core sr6_checker u_sr6_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire

>>> dv/testbench.sv
// testbench for the symmetric 6x6 rank update accumulator core: directed and random items
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    sr6_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    sr6_pkg::out_item_t m_data;

    sr6_pkg::in_item_t  pending_items[$];
    sr6_pkg::out_item_t expected_results[$];
    logic signed [63:0] entries[sr6_pkg::NUM_ENTRIES];
    bit        stimulus_done = 1'b0;
    int        errors = 0;
    int        send_wait = 0;
    int        recv_wait = 0;

    always #5 aclk = ~aclk;

    symmetric_6x6_rank_update_accumulator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic int entry_slot(input int r, input int c);
        int t;
        if (r > c) begin
            t = r;
            r = c;
            c = t;
        end
        return r * 6 - (r * (r - 1)) / 2 + (c - r);
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] x, input int bits,
                                                inout bit sat);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (x < lo) begin
            sat = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic void accumulate(input int idx, input logic signed [63:0] v, inout bit sat);
        entries[idx] = clip(entries[idx] + v, 48, sat);
    endfunction

    function automatic logic signed [15:0] col_lane(input sr6_pkg::in_item_t it, input int k,
                                                    input int l);
        logic [31:0] c;
        case (k)
            0: c = it.col_0;
            1: c = it.col_1;
            2: c = it.col_2;
            3: c = it.col_3;
            4: c = it.col_4;
            default: c = it.col_5;
        endcase
        return l ? c[31:16] : c[15:0];
    endfunction

    function automatic sr6_pkg::out_item_t predict_result(input sr6_pkg::in_item_t it);
        sr6_pkg::out_item_t res;
        bit sat;
        logic signed [63:0] va[6], vb[6], ua[6], ub[6];
        logic signed [63:0] w11, w21, w12, w22, d;
        bit two;
        sat = 1'b0;
        res = '0;
        case (it.opcode)
            sr6_pkg::OP_CLEAR: foreach (entries[k]) entries[k] = 0;
            sr6_pkg::OP_RANK1, sr6_pkg::OP_RANK2: begin
                two = (it.opcode == sr6_pkg::OP_RANK2);
                w11 = $signed(it.weight[15:0]);
                w21 = two ? $signed(it.weight[31:16]) : 0;
                w12 = two ? $signed(it.weight[47:32]) : 0;
                w22 = two ? $signed(it.weight[63:48]) : 0;
                for (int i = 0; i < 6; i++) begin
                    va[i] = col_lane(it, i, 0);
                    vb[i] = two ? col_lane(it, i, 1) : 0;
                    ua[i] = clip((w11 * va[i] + w21 * vb[i]) >>> 12, 16, sat);
                    ub[i] = clip((w12 * va[i] + w22 * vb[i]) >>> 12, 16, sat);
                end
                for (int i = 0; i < 6; i++)
                    for (int j = i; j < 6; j++) begin
                        d = ua[i] * va[j] + ub[i] * vb[j];
                        accumulate(entry_slot(i, j), d, sat);
                    end
            end
            sr6_pkg::OP_ADD:
                if (it.entry_row < 6 && it.entry_col < 6)
                    accumulate(entry_slot(it.entry_row, it.entry_col), it.entry_value, sat);
            sr6_pkg::OP_READ:
                if (it.entry_row < 6 && it.entry_col < 6)
                    res.read_value = entries[entry_slot(it.entry_row, it.entry_col)][47:0];
            default: ;
        endcase
        res.saturated = sat;
        return res;
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sr6_pkg::in_item_t rand_item();
        sr6_pkg::in_item_t it;
        int p;
        it = '0;
        p = $urandom_range(0, 99);
        if (p < 3) it.opcode = sr6_pkg::OP_CLEAR;
        else if (p < 25) it.opcode = sr6_pkg::OP_RANK1;
        else if (p < 50) it.opcode = sr6_pkg::OP_RANK2;
        else if (p < 65) it.opcode = sr6_pkg::OP_ADD;
        else if (p < 95) it.opcode = sr6_pkg::OP_READ;
        else it.opcode = 3'($urandom_range(5, 7));
        it.col_0 = {rand_elem(), rand_elem()};
        it.col_1 = {rand_elem(), rand_elem()};
        it.col_2 = {rand_elem(), rand_elem()};
        it.col_3 = {rand_elem(), rand_elem()};
        it.col_4 = {rand_elem(), rand_elem()};
        it.col_5 = {rand_elem(), rand_elem()};
        it.weight = {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        it.entry_row = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
        it.entry_col = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
        case ($urandom_range(0, 4))
            0: it.entry_value = 48'h7fff_ffff_ffff;
            1: it.entry_value = 48'h8000_0000_0000;
            default: it.entry_value = {$urandom, $urandom};
        endcase
        return it;
    endfunction

    function automatic sr6_pkg::in_item_t make_item(input logic [2:0] op, input logic [31:0] col,
                                                    input logic [63:0] w, input int r,
                                                    input int c, input logic [47:0] v);
        sr6_pkg::in_item_t it;
        it = '0;
        it.opcode = op;
        it.col_0 = col;
        it.col_1 = col;
        it.col_2 = col;
        it.col_3 = col;
        it.col_4 = col;
        it.col_5 = col;
        it.weight = w;
        it.entry_row = 3'(r);
        it.entry_col = 3'(c);
        it.entry_value = v;
        return it;
    endfunction

    initial begin
        foreach (entries[k]) entries[k] = 0;
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_ADD, 0, 0, 1, 4, 48'h7fff_ffff_ffff));
        pending_items.push_back(make_item(sr6_pkg::OP_ADD, 0, 0, 4, 1, 48'h0000_0000_0001));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 4, 1, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_ADD, 0, 0, 2, 2, 48'h8000_0000_0000));
        pending_items.push_back(make_item(sr6_pkg::OP_ADD, 0, 0, 2, 2, 48'hffff_ffff_ffff));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 2, 2, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_ADD, 0, 0, 6, 2, 48'h1));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 7, 7, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_RANK1, 32'h8000_8000,
                                          64'h8000_8000_8000_8000, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_RANK2, 32'h7fff_7fff,
                                          64'h7fff_7fff_7fff_7fff, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_RANK2, 32'h8000_7fff,
                                          64'h8000_7fff_8000_7fff, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 5, 5, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_RANK1, 32'h1000_1000,
                                          64'hffff_ffff_ffff_1000, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 3, 0, 0));
        pending_items.push_back(make_item(3'd5, '1, '1, 0, 0, '1));
        pending_items.push_back(make_item(3'd7, '1, '1, 1, 1, '1));
        pending_items.push_back(make_item(sr6_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(sr6_pkg::OP_READ, 0, 0, 0, 5, 0));
        for (int n = 0; n < 800; n++) pending_items.push_back(rand_item());
        stimulus_done = 1'b1;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
                s_valid <= 1'b0;
                send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
            end else if (!s_valid) begin
                if (send_wait > 0) send_wait <= send_wait - 1;
                else if (pending_items.size() > 0) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    sr6_pkg::out_item_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (exp_res.read_value !== m_data.read_value) begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 exp_res.read_value, m_data.read_value);
                        errors++;
                    end
                    if (exp_res.saturated !== m_data.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_res.saturated, m_data.saturated);
                        errors++;
                    end
                end
                recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        @(posedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/sr6_pkg.sv
sv/sr6_lane.sv
sv/sr6_merge.sv
sv/symmetric_6x6_rank_update_accumulator_core.sv
sv/sr6_checker.sv
dv/testbench.sv
